// ----- sv/ipp_pkg.sv -----
package ipp_pkg;

  // fixed field widths
  localparam int unsigned COORD_W  = 24;
  localparam int unsigned RADIUS_W = 20;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned FORCE_W  = 32;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // contact gap added to the sum of both radii, in nm
  localparam int unsigned CONTACT_GAP_NM = 200;

  // arithmetic widths of the pair check
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned SUM_W   = SQ_W + 2;
  localparam int unsigned REACH_W = RADIUS_W + 2;
  localparam int unsigned REACH2_W = 2 * REACH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPDATE_PERIOD = 1'b0,
    CFG_SWIM_FORCE    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_EVAL,
    ST_DRAIN
  } phase_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [RADIUS_W-1:0]       sphere_radius;
    logic [STEP_W-1:0]         timestep;
    logic                      last_particle;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        particle_index;
    logic                      isolated;
    logic signed [FORCE_W-1:0] force_z_add;
    logic                      last_result;
  } out_item_t;

  // one stored sphere
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RADIUS_W-1:0]       r;
  } sphere_t;

  localparam int unsigned SPHERE_W = $bits(sphere_t);

  // tag that travels with one pair down the check pipeline
  typedef struct packed {
    logic               valid;
    logic               distinct;
    logic               row_end;
    logic               last;
    logic [INDEX_W-1:0] idx;
  } pair_tag_t;

  // remainder unit status
  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] rem;
  } rem_stat_t;

endpackage

// ----- sv/ipp_ram.sv -----
module ipp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ipp_rem.sv -----
module ipp_rem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ipp_pkg::STEP_W-1:0]   num_i,
  input  logic [ipp_pkg::PERIOD_W-1:0] den_i,
  output ipp_pkg::rem_stat_t           stat_o
);
  import ipp_pkg::*;

  localparam int unsigned CNT_W = $clog2(STEP_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0]   num_q, num_d;
  logic [PERIOD_W:0]   trial;

  // one restoring step per cycle, dividend bits from the top
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    trial  = {rem_q, num_q[STEP_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = num_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_i}) begin
        rem_d = PERIOD_W'(trial - {1'b0, den_i});
      end else begin
        rem_d = trial[PERIOD_W-1:0];
      end
      num_d = {num_q[STEP_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEP_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;

endmodule

// ----- sv/isolated_particle_push_top.sv -----
// Isolated-particle push.
// Input channel (in_valid_i / in_ready_o / in_data_i): one sphere per request.
// Spheres are written into two copies of the sphere memory, one per cycle,
// up to MAX_PARTICLES; further spheres of a batch are dropped. The request with
// last_particle set closes the batch and starts evaluation; in_ready_o stays
// low until the last result of the batch has entered the output register.
// Evaluation: a remainder unit decides whether timestep is a multiple
// of update_period, then all n*n ordered pairs are read from the two memories
// at one pair per cycle while the output is not stalled and pass a four-stage
// check pipeline (read, diff, square, sum and compare). The pair sweep
// through the two memory read ports sets how long a batch takes.
// Output channel (out_valid_o / out_ready_i / out_data_o): one result per
// sphere in load order, the last one flagged. The result sits in an output
// register; while it is not taken, the whole check pipeline holds.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i): user writes only while
// idle; the block does not enforce it. Reset: update_period = 1, swim_force = 0,
// empty batch, no results pending; the sphere memory needs no clearing.
module isolated_particle_push_top #(
  parameter int unsigned MAX_PARTICLES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ipp_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ipp_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [ipp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ipp_pkg::*;

  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);

  // configuration registers
  logic [PERIOD_W-1:0]       period_q;
  logic signed [FORCE_W-1:0] force_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_W'(1);
      force_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UPDATE_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_SWIM_FORCE:    force_q  <= cfg_data_i[FORCE_W-1:0];
      endcase
    end
  end

  phase_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] n_q, n_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d;
  logic          push_q, push_d;
  logic          in_fire, store_en, adv, ram_re;
  logic [AW-1:0] last_idx;
  rem_stat_t     rem_stat;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign store_en   = in_fire && (count_q < CW'(MAX_PARTICLES));
  assign last_idx   = AW'(n_q - CW'(1));
  assign ram_re     = adv && (state_q == ST_EVAL);

  // sphere memories: one read at row index, one at column index
  sphere_t wr_sphere, sph_a, sph_b;
  assign wr_sphere = '{x: in_data_i.pos_x, y: in_data_i.pos_y, z: in_data_i.pos_z,
                       r: in_data_i.sphere_radius};

  ipp_ram #(.WIDTH(SPHERE_W), .DEPTH(MAX_PARTICLES)) u_ram_row (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_sphere),
    .re_i    (ram_re),
    .raddr_i (i_q),
    .rdata_o (sph_a)
  );

  ipp_ram #(.WIDTH(SPHERE_W), .DEPTH(MAX_PARTICLES)) u_ram_col (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_sphere),
    .re_i    (ram_re),
    .raddr_i (j_q),
    .rdata_o (sph_b)
  );

  // timestep remainder
  ipp_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire && in_data_i.last_particle),
    .num_i   (in_data_i.timestep),
    .den_i   (period_q),
    .stat_o  (rem_stat)
  );

  // check pipeline registers
  pair_tag_t t1_q, t2_q, t3_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic [REACH_W-1:0]       reach_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q, sqz_q;
  logic [REACH2_W-1:0]      reach2_q;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [REACH2_W-1:0]      pr;
  logic [SUM_W-1:0]         dist2;
  logic                     hit, iso_q, iso_d, iso_bit;
  pair_tag_t                t1_d;
  out_item_t                out_q;
  logic                     out_valid_q, out_load;

  assign adv = !(out_valid_q && !out_ready_i);

  // sequencer: load, remainder, pair sweep, drain
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    i_d     = i_q;
    j_d     = j_q;
    push_d  = push_q;
    t1_d    = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          count_d = store_en ? count_q + CW'(1) : count_q;
          if (in_data_i.last_particle) begin
            n_d     = count_d;
            count_d = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          push_d  = (period_q != '0) && (rem_stat.rem == '0);
          i_d     = '0;
          j_d     = '0;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        t1_d.valid    = 1'b1;
        t1_d.distinct = (i_q != j_q);
        t1_d.row_end  = (j_q == last_idx);
        t1_d.last     = (j_q == last_idx) && (i_q == last_idx);
        t1_d.idx      = INDEX_W'(i_q);
        if (adv) begin
          if (j_q == last_idx) begin
            j_d = '0;
            if (i_q == last_idx) begin
              state_d = ST_DRAIN;
            end else begin
              i_d = i_q + AW'(1);
            end
          end else begin
            j_d = j_q + AW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (out_load && t3_q.last) begin
          state_d = ST_LOAD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      push_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      push_q  <= push_d;
    end
  end

  // pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
    end else if (adv) begin
      t1_q <= t1_d;
      t2_q <= t1_q;
      t3_q <= t2_q;
    end
  end

  // differences and reach
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q    <= {sph_a.x[COORD_W-1], sph_a.x} - {sph_b.x[COORD_W-1], sph_b.x};
      dy_q    <= {sph_a.y[COORD_W-1], sph_a.y} - {sph_b.y[COORD_W-1], sph_b.y};
      dz_q    <= {sph_a.z[COORD_W-1], sph_a.z} - {sph_b.z[COORD_W-1], sph_b.z};
      reach_q <= {2'b00, sph_a.r} + {2'b00, sph_b.r} + REACH_W'(CONTACT_GAP_NM);
    end
  end

  // squares
  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;
  assign pz = dz_q * dz_q;
  assign pr = reach_q * reach_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q    <= px[SQ_W-1:0];
      sqy_q    <= py[SQ_W-1:0];
      sqz_q    <= pz[SQ_W-1:0];
      reach2_q <= pr;
    end
  end

  // sum, compare and row accumulation
  assign dist2    = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
  assign hit      = t3_q.distinct && (dist2 <= SUM_W'(reach2_q));
  assign iso_bit  = iso_q && !hit;
  assign out_load = adv && t3_q.valid && t3_q.row_end;

  always_comb begin
    iso_d = iso_q;
    if (adv && t3_q.valid) begin
      iso_d = t3_q.row_end ? 1'b1 : iso_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      iso_q <= iso_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.particle_index <= t3_q.idx;
      out_q.isolated       <= iso_bit;
      out_q.force_z_add    <= (iso_bit && push_q) ? force_q : '0;
      out_q.last_result    <= t3_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the batch closes into the remainder phase
  a_close_to_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_particle) |=> (state_q == ST_DIV))
    else $error("closing request did not start the remainder phase");

  // a stalled result freezes the memory reads
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !ram_re)
    else $error("memory read advanced while the result was stalled");

  // fill count stays within the memory
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_en |=> (count_q <= CW'(MAX_PARTICLES)))
    else $error("fill count beyond capacity");

endmodule
